/* rtl/drop_oldest_sample_ring_defines.svh */
// ----------------------------------------------------------------------------
// drop_oldest_sample_ring_defines
// Assertion macros for the drop-oldest sample ring.
// Each macro expands to a labelled concurrent assertion, or to nothing when
// SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DROP_OLDEST_SAMPLE_RING_DEFINES_SVH
`define DROP_OLDEST_SAMPLE_RING_DEFINES_SVH

`ifndef SYNTH

// Clocked on clk, switched off while rst_n is low.
`define DOSR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dosr assertion failed");

// Clocked on clk, checked during reset as well.
`define DOSR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("dosr assertion failed");

`else

`define DOSR_ASSERT(label, prop)

`define DOSR_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* rtl/dosr_pkg.sv */
// ----------------------------------------------------------------------------
// dosr_pkg
// Shared codes, field layout and controller/datapath handshake types for the
// drop-oldest sample ring.
// ----------------------------------------------------------------------------
`default_nettype none

package dosr_pkg;

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_POST  = 2'd0;
    localparam logic [1:0] OP_DRAIN = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result kinds carried on m_tuser
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DIAG   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOURCE = 2'd0;
    localparam logic [1:0] CFG_FIELD  = 2'd1;
    localparam logic [1:0] CFG_TYPE   = 2'd2;
    localparam logic [1:0] CFG_FLAGS  = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Field widths
    localparam int TAG_W    = 36;
    localparam int VALUE_W  = 64;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = TAG_W + VALUE_W + TIME_W;
    localparam int DRAIN_W  = 6;
    localparam int CNT_W    = 32;

    localparam int IN_TDATA_W  = ((SLOT_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + DRAIN_W + 2 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Commands from controller to datapath
    typedef struct packed {
        logic post;
        logic clear;
        logic drain_start;
        logic rd_issue;
        logic load_sample;
        logic load_diag;
        logic load_done;
    } dosr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic queued_zero;
        logic queued_one;
        logic drops_changed;
        logic out_free;
    } dosr_stat_t;

endpackage

`default_nettype wire

/* rtl/dosr_ctrl.sv */
// ----------------------------------------------------------------------------
// dosr_ctrl
// Sequencer: takes operations from the input channel and steps a drain
// through sample, diagnostic and done words.
// ----------------------------------------------------------------------------
`default_nettype none

module dosr_ctrl
    import dosr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic [1:0] s_tuser,
    output logic            s_tready,
    input  wire dosr_stat_t stat,
    output dosr_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_SAMPLE = 3'd2;
    localparam logic [2:0] S_DIAG   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_POST:  cmd.post = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_DRAIN:
                        begin
                            cmd.drain_start = 1'b1;
                            if (!stat.queued_zero)
                                state_next = S_FETCH;
                            else if (stat.drops_changed)
                                state_next = S_DIAG;
                            else
                                state_next = S_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_SAMPLE;
            end
            S_SAMPLE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_sample = 1'b1;
                    if (stat.queued_one)
                        state_next = stat.drops_changed ? S_DIAG : S_DONE;
                    else
                        // prefetch the next slot alongside this load
                        cmd.rd_issue = 1'b1;
                end
            end
            S_DIAG:
            begin
                if (stat.out_free)
                begin
                    cmd.load_diag = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/dosr_datapath.sv */
// ----------------------------------------------------------------------------
// dosr_datapath
// Slot memory, ring pointers, counters, diagnostic registers and the output
// word register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "drop_oldest_sample_ring_defines.svh"

module dosr_datapath
    import dosr_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire dosr_cmd_t              cmd,
    output dosr_stat_t                  stat,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int QW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [QW-1:0] DEPTH_Q   = QW'(RING_DEPTH);

    logic [SLOT_W-1:0] slot_ram [RING_DEPTH];
    logic [SLOT_W-1:0] rdata_reg;
    logic [AW-1:0]     rd_addr;

    logic [AW-1:0]     write_slot_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_inc;
    logic [AW-1:0]     tail_slot;
    logic [QW-1:0]     queued_reg;
    logic [QW-1:0]     drained_reg;
    logic [QW-1:0]     ws_ext;
    logic [CNT_W-1:0]  posted_reg;
    logic [CNT_W-1:0]  dropped_reg;
    logic [CNT_W-1:0]  reported_reg;

    logic [7:0]        diag_source_reg;
    logic [7:0]        diag_field_reg;
    logic [3:0]        diag_type_reg;
    logic [7:0]        diag_flags_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic              out_last_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [DRAIN_W-1:0] out_drained_reg;
    logic [CNT_W-1:0]  out_posted_reg;
    logic [CNT_W-1:0]  out_dropped_reg;

    logic              out_load;

    assign rd_ptr_inc = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
    assign rd_addr    = cmd.load_sample ? rd_ptr_inc : rd_ptr_reg;

    // oldest slot: write_slot - queued, wrapped into the ring
    assign ws_ext    = QW'(write_slot_reg);
    assign tail_slot = (ws_ext >= queued_reg) ? AW'(ws_ext - queued_reg)
                                              : AW'(ws_ext + DEPTH_Q - queued_reg);

    assign out_load = cmd.load_sample || cmd.load_diag || cmd.load_done;

    assign stat.queued_zero   = (queued_reg == '0);
    assign stat.queued_one    = (queued_reg == QW'(1));
    assign stat.drops_changed = (dropped_reg != reported_reg);
    assign stat.out_free      = !out_valid_reg || m_tready;

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.post)
            slot_ram[write_slot_reg] <= s_tdata[SLOT_W-1:0];
        if (cmd.rd_issue)
            rdata_reg <= slot_ram[rd_addr];
    end

    // Ring pointers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            rd_ptr_reg     <= '0;
            queued_reg     <= '0;
            drained_reg    <= '0;
            posted_reg     <= '0;
            dropped_reg    <= '0;
            reported_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            write_slot_reg <= '0;
            queued_reg     <= '0;
            posted_reg     <= '0;
            dropped_reg    <= '0;
            reported_reg   <= '0;
        end
        else
        begin
            if (cmd.post)
            begin
                posted_reg     <= posted_reg + 1'b1;
                write_slot_reg <= (write_slot_reg == LAST_SLOT) ? '0
                                                                : write_slot_reg + 1'b1;
                // full ring: overwrite the oldest and count a drop
                if (queued_reg == DEPTH_Q)
                    dropped_reg <= dropped_reg + 1'b1;
                else
                    queued_reg <= queued_reg + 1'b1;
            end
            if (cmd.drain_start)
            begin
                rd_ptr_reg  <= tail_slot;
                drained_reg <= '0;
            end
            if (cmd.load_sample)
            begin
                rd_ptr_reg  <= rd_ptr_inc;
                queued_reg  <= queued_reg - 1'b1;
                drained_reg <= drained_reg + 1'b1;
            end
            if (cmd.load_diag)
                reported_reg <= dropped_reg;
        end
    end

    // Diagnostic record registers, unaffected by a clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_source_reg <= '0;
            diag_field_reg  <= '0;
            diag_type_reg   <= '0;
            diag_flags_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE: diag_source_reg <= cfg_wdata;
                CFG_FIELD:  diag_field_reg  <= cfg_wdata;
                CFG_TYPE:   diag_type_reg   <= cfg_wdata[3:0];
                CFG_FLAGS:  diag_flags_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_posted_reg  <= posted_reg;
            out_dropped_reg <= dropped_reg;
        end
        if (cmd.load_sample)
        begin
            out_kind_reg    <= KIND_SAMPLE;
            out_last_reg    <= 1'b0;
            out_tag_reg     <= rdata_reg[TAG_W-1:0];
            out_value_reg   <= rdata_reg[TAG_W +: VALUE_W];
            out_time_reg    <= rdata_reg[TAG_W + VALUE_W +: TIME_W];
            out_drained_reg <= '0;
        end
        else if (cmd.load_diag)
        begin
            out_kind_reg    <= KIND_DIAG;
            out_last_reg    <= 1'b0;
            out_tag_reg     <= {8'd0, diag_flags_reg, diag_type_reg,
                                diag_field_reg, diag_source_reg};
            out_value_reg   <= {{(VALUE_W - CNT_W){1'b0}}, dropped_reg};
            out_time_reg    <= '0;
            out_drained_reg <= '0;
        end
        else if (cmd.load_done)
        begin
            out_kind_reg    <= KIND_DONE;
            out_last_reg    <= 1'b1;
            out_tag_reg     <= '0;
            out_value_reg   <= '0;
            out_time_reg    <= '0;
            out_drained_reg <= DRAIN_W'(drained_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                       out_dropped_reg, out_posted_reg, out_drained_reg,
                       out_time_reg, out_value_reg, out_tag_reg};

    `DOSR_ASSERT(a_queued_bounded, queued_reg <= DEPTH_Q)
    `DOSR_ASSERT(a_sample_needs_queue, cmd.load_sample |-> (queued_reg != '0))
    `DOSR_ASSERT(a_diag_marks_reported, cmd.load_diag |=> (reported_reg == dropped_reg))
    `DOSR_ASSERT(a_done_is_last, cmd.load_done |=> (m_tvalid && m_tlast))

endmodule

`default_nettype wire

/* rtl/drop_oldest_sample_ring.sv */
// ----------------------------------------------------------------------------
// drop_oldest_sample_ring
// Input channel s_*: one word per operation, code on s_tuser (post, drain,
// clear). Posts and clears are taken one per cycle and give no result; a full
// ring overwrites its oldest sample and counts a drop.
// Output channel m_*: a drain gives the queued samples oldest first, then a
// drop diagnostic word if the drop total moved since the last report, then a
// done word (m_tlast high) carrying the drained count.
// A drain holds the input until its done word is loaded. With m_tready
// high one slot streams per cycle, set by the registered read port of the
// slot memory, after a fetch state at the start; the first sample passes
// the fetch state and the read register before the output register, and
// an empty ring goes straight to the diagnostic or done word.
// The output register lets the next operation be taken while the done word
// still waits. A stalled receiver holds the current word and pauses the drain.
// Reset empties the ring and zeroes counters and diagnostic registers; slot
// contents are left as they are and are only read once written.
// Configuration writes (cfg_we) are registered and should be made while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_oldest_sample_ring
    import dosr_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // source[7:0] field[15:8] type[19:16] flags[27:20] exponent[35:28]
    // value[99:36] time[131:100], zero pad above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // source[7:0] field[15:8] type[19:16] flags[27:20] exponent[35:28]
    // value[99:36] time[131:100] drained_count[137:132] posted_total[169:138]
    // dropped_total[201:170], zero pad above
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // result_kind[1:0]
    output logic [1:0]                  m_tuser,
    // last_of_run
    output logic                        m_tlast
);

    dosr_cmd_t  cmd;
    dosr_stat_t stat;

    dosr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dosr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
